FILE: rtl/gbn_pkg.sv
// Shared types and constants for the go-back-n sender window controller.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package gbn_pkg;

    localparam int unsigned MAX_WINDOW  = 16;
    localparam int unsigned COUNT_WIDTH = 16;
    localparam int unsigned SEQ_SPACE   = 2 * MAX_WINDOW + 1;
    localparam int unsigned WIN_W       = $clog2(MAX_WINDOW + 1);
    localparam int unsigned SEQ_W       = 6;
    localparam int unsigned CFG_W       = 5;
    localparam int unsigned CMD_W       = 2;
    localparam int unsigned FLAG_W      = 3;
    localparam int unsigned STATUS_W    = 3;
    localparam int unsigned WIN_RESET   = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [FLAG_W-1:0] FLAG_ACK = 3'd3;
    localparam logic [FLAG_W-1:0] FLAG_NAK = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_START   = 2'd0,
        CMD_SLOT    = 2'd1,
        CMD_RESP    = 2'd2,
        CMD_TIMEOUT = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE           = 3'd0,
        ST_FRAME_SENT     = 3'd1,
        ST_ACK_ACCEPTED   = 3'd2,
        ST_IGNORED        = 3'd3,
        ST_NAK_REWIND     = 3'd4,
        ST_CORRUPT_REWIND = 3'd5,
        ST_TIMEOUT_REWIND = 3'd6,
        ST_BAD_SEQ        = 3'd7
    } t_status;

    typedef enum logic {
        BK_FETCH = 1'b0,
        BK_APPLY = 1'b1
    } t_bk_state;

    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic [COUNT_WIDTH-1:0] msg_count;
        logic [FLAG_W-1:0]      resp_flags;
        logic [SEQ_W-1:0]       resp_seq;
        logic                   resp_crc_ok;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   frame_valid;
        logic [COUNT_WIDTH-1:0] frame_index;
        logic [SEQ_W-1:0]       frame_seq;
        logic                   all_done;
        logic [SEQ_W-1:0]       next_send_seq;
    } t_out_word;

    // Pre-decoded word as held in the queue
    typedef struct packed {
        t_cmd                   cmd;
        logic [COUNT_WIDTH-1:0] count;
        logic                   is_ack;
        logic                   is_ack_or_nak;
        logic [SEQ_W-1:0]       seq;
        logic                   crc_ok;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: rtl/go_back_n_sender_window.sv
// Go-back-N sender window controller: top level joining front, queue and back stages.
// Depends on gbn_pkg, gbn_front, gbn_queue and gbn_back.
//
// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one protocol event
//   per word: start, send slot free, response received or wait timeout.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly one
//   result word per input word, in order: status, the frame to transmit (if any),
//   the all-done flag and the sequence number after the last frame sent.
//   i_cfg_we / i_cfg_wdata write the window size; it takes effect at the next start.
// Flow
//   A word is taken into the front register, moves through a two-entry queue,
//   then the back stage decides on the action in its fetch state and, in its
//   apply state, updates the window state and loads the result register. The
//   back stage fetches a new word only after applying the last one, and an apply
//   waits while a stalled result is held.
// Reset
//   i_rst_n is synchronous, active low: window state and marks clear, window
//   size returns to 4, all channels go empty. No clearing pass is needed.
// Back-pressure
//   A stalled result holds; the queue keeps filling until full, then o_in_stall rises.
module go_back_n_sender_window (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [gbn_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  gbn_pkg::t_in_word         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output gbn_pkg::t_out_word        o_out_data
);

    // front -> queue
    logic             push;
    gbn_pkg::t_job    job;
    // queue -> back
    gbn_pkg::t_job    head;
    gbn_pkg::t_q_stat q_stat;
    logic             pop;

    // Front: registers and decodes one word, pushes when the queue has room
    gbn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_job      (job)
    );

    // Queue: lets front keep taking words while the result side is stalled
    gbn_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (job),
        .i_pop    (pop),
        .o_head   (head),
        .o_q_stat (q_stat)
    );

    // Back: owns window state, the accepted-mark flags and the result register
    gbn_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_stat    (q_stat),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // no push into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("queue push while full");

    // back only takes a word that is present
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("queue pop while empty");

    // a frame is only offered together with the frame-sent status
    a_frame_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_valid) |->
            (o_out_data.status == gbn_pkg::ST_FRAME_SENT))
        else $error("frame offered with wrong status");

    // a pop is followed by a result load, so two pops never come back to back when the result is not stalled
    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !(o_out_valid && i_out_stall)) |=> !pop)
        else $error("back stage popped on consecutive cycles");

endmodule

FILE: rtl/gbn_front.sv
// Input stage: registers the incoming word and decodes command and reply flags.
// Depends on gbn_pkg; feeds gbn_queue.
module gbn_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  gbn_pkg::t_in_word i_in_data,
    input  gbn_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output gbn_pkg::t_job     o_job
);

    logic          r_valid;
    logic          n_valid;
    gbn_pkg::t_job r_job;
    gbn_pkg::t_job n_job;
    logic          accept;

    assign o_in_stall = r_valid && i_q_stat.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_stat.full;
    assign o_job      = r_job;

    always_comb begin
        n_job.cmd           = gbn_pkg::t_cmd'(i_in_data.command);
        n_job.count         = i_in_data.msg_count;
        n_job.is_ack        = (i_in_data.resp_flags == gbn_pkg::FLAG_ACK);
        n_job.is_ack_or_nak = (i_in_data.resp_flags == gbn_pkg::FLAG_ACK) ||
                              (i_in_data.resp_flags == gbn_pkg::FLAG_NAK);
        n_job.seq           = i_in_data.resp_seq;
        n_job.crc_ok        = i_in_data.resp_crc_ok;
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job <= n_job;
        end
    end

endmodule

FILE: rtl/gbn_queue.sv
// Short FIFO of decoded words between the front and back stages.
// Depends on gbn_pkg (t_job, t_q_stat, QUEUE_DEPTH, a power of two).
module gbn_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gbn_pkg::t_job    i_job,
    input  logic             i_pop,
    output gbn_pkg::t_job    o_head,
    output gbn_pkg::t_q_stat o_q_stat
);

    localparam int unsigned PTR_W = (gbn_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(gbn_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(gbn_pkg::QUEUE_DEPTH + 1);

    gbn_pkg::t_job    r_entry [gbn_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_head         = r_entry[r_rd_ptr];
    assign o_q_stat.full  = (r_count == CNT_W'(gbn_pkg::QUEUE_DEPTH));
    assign o_q_stat.empty = (r_count == '0);

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: rtl/gbn_back.sv
// Window engine: decides on the queued word, then updates window state and the result register.
// Depends on gbn_pkg; takes words from gbn_queue.
module gbn_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [gbn_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  gbn_pkg::t_q_stat            i_q_stat,
    input  gbn_pkg::t_job               i_head,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output gbn_pkg::t_out_word          o_out_data
);

    localparam int unsigned SEQ_W = gbn_pkg::SEQ_W;
    localparam int unsigned WIN_W = gbn_pkg::WIN_W;
    localparam int unsigned CW    = gbn_pkg::COUNT_WIDTH;
    localparam int unsigned MS    = gbn_pkg::SEQ_SPACE;
    localparam int unsigned MIX_W = $clog2(MS);

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_START,
        ACT_SEND,
        ACT_SLIDE,
        ACT_IGNORE,
        ACT_REWIND_NAK,
        ACT_REWIND_CORRUPT,
        ACT_REWIND_TIMEOUT,
        ACT_BAD_SEQ
    } t_action;

    function automatic logic [WIN_W-1:0] clamp_window(input logic [gbn_pkg::CFG_W-1:0] w);
        logic [WIN_W-1:0] res;
        if (w == '0) begin
            res = WIN_W'(1);
        end else if (w > gbn_pkg::CFG_W'(gbn_pkg::MAX_WINDOW)) begin
            res = WIN_W'(gbn_pkg::MAX_WINDOW);
        end else begin
            res = WIN_W'(w);
        end
        return res;
    endfunction

    gbn_pkg::t_bk_state          r_state;
    gbn_pkg::t_bk_state          n_state;
    logic [gbn_pkg::CFG_W-1:0]   r_window_size;
    logic [WIN_W-1:0]            r_act_window;
    logic [WIN_W-1:0]            n_act_window;
    logic                        r_started;
    logic                        n_started;
    logic [CW-1:0]               r_base_index;
    logic [CW-1:0]               n_base_index;
    logic [CW-1:0]               r_next_index;
    logic [CW-1:0]               n_next_index;
    logic [SEQ_W-1:0]            r_base_seq;
    logic [SEQ_W-1:0]            n_base_seq;
    logic [SEQ_W-1:0]            r_next_seq;
    logic [SEQ_W-1:0]            n_next_seq;
    logic [WIN_W-1:0]            r_slots_free;
    logic [WIN_W-1:0]            n_slots_free;
    logic [CW-1:0]               r_total;
    logic [CW-1:0]               n_total;
    logic [MS-1:0]               r_marks;
    logic [MS-1:0]               n_marks;
    logic [WIN_W-1:0]            r_marks_count;
    logic [WIN_W-1:0]            n_marks_count;
    t_action                     r_action;
    t_action                     d_action;
    logic [CW-1:0]               r_count;
    logic                        r_out_valid;
    logic                        n_out_valid;
    gbn_pkg::t_out_word          r_out_data;
    gbn_pkg::t_out_word          n_out_data;
    gbn_pkg::t_status            n_status;
    logic                        fetch_en;
    logic                        apply_en;
    logic [SEQ_W-1:0]            seq_mod;
    logic [SEQ_W:0]              next_seq_inc;
    logic [SEQ_W:0]              base_seq_inc;
    logic [SEQ_W-1:0]            old_seq;
    logic                        mark_hit;
    logic                        waiting;

    assign o_pop       = fetch_en;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // modulus 2W+1 of the window in use
    assign seq_mod      = SEQ_W'({r_act_window, 1'b1});
    assign next_seq_inc = {1'b0, r_next_seq} + 1'b1;
    assign base_seq_inc = {1'b0, r_base_seq} + 1'b1;
    // sequence W places behind base, modulo 2W+1
    assign old_seq = (r_base_seq >= SEQ_W'(r_act_window)) ?
                     (r_base_seq - SEQ_W'(r_act_window)) :
                     (r_base_seq + SEQ_W'(r_act_window) + 1'b1);
    assign mark_hit = (i_head.seq < SEQ_W'(MS)) ? r_marks[i_head.seq[MIX_W-1:0]] : 1'b0;
    assign waiting  = (r_slots_free == '0) ||
                      ((r_next_index == r_total) && (r_base_index != r_total));

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbn_pkg::BK_FETCH: begin
                if (!i_q_stat.empty) begin
                    n_state = gbn_pkg::BK_APPLY;
                end
            end
            gbn_pkg::BK_APPLY: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = gbn_pkg::BK_FETCH;
                end
            end
            default: n_state = gbn_pkg::BK_FETCH;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        fetch_en = 1'b0;
        apply_en = 1'b0;
        unique case (r_state)
            gbn_pkg::BK_FETCH: fetch_en = !i_q_stat.empty;
            gbn_pkg::BK_APPLY: apply_en = !r_out_valid || !i_out_stall;
            default: begin
                fetch_en = 1'b0;
                apply_en = 1'b0;
            end
        endcase
    end

    // decision on the head word against current window state
    always_comb begin
        d_action = ACT_NONE;
        unique case (i_head.cmd)
            gbn_pkg::CMD_START: d_action = ACT_START;
            gbn_pkg::CMD_SLOT: begin
                if ((r_slots_free != '0) && (r_next_index != r_total)) begin
                    d_action = ACT_SEND;
                end
            end
            gbn_pkg::CMD_RESP: begin
                priority if (i_head.seq >= seq_mod) begin
                    d_action = ACT_BAD_SEQ;
                end else if (i_head.is_ack && (i_head.seq == r_base_seq)) begin
                    priority if (!i_head.crc_ok) begin
                        d_action = ACT_REWIND_CORRUPT;
                    end else if (r_base_index == r_next_index) begin
                        d_action = ACT_IGNORE;
                    end else begin
                        d_action = ACT_SLIDE;
                    end
                end else if (mark_hit) begin
                    d_action = ACT_IGNORE;
                end else if ((i_head.seq != r_base_seq) && i_head.is_ack_or_nak) begin
                    d_action = ACT_IGNORE;
                end else begin
                    d_action = ACT_REWIND_NAK;
                end
            end
            gbn_pkg::CMD_TIMEOUT: begin
                if (waiting) begin
                    d_action = ACT_REWIND_TIMEOUT;
                end
            end
            default: d_action = ACT_NONE;
        endcase
    end

    // state update for the decided action
    always_comb begin
        n_act_window  = r_act_window;
        n_started     = r_started;
        n_base_index  = r_base_index;
        n_next_index  = r_next_index;
        n_base_seq    = r_base_seq;
        n_next_seq    = r_next_seq;
        n_slots_free  = r_slots_free;
        n_total       = r_total;
        n_marks       = r_marks;
        n_marks_count = r_marks_count;
        n_status      = gbn_pkg::ST_NONE;
        n_out_data    = '0;
        unique case (r_action)
            ACT_START: begin
                n_act_window  = clamp_window(r_window_size);
                n_started     = 1'b1;
                n_total       = r_count;
                n_base_index  = '0;
                n_next_index  = '0;
                n_base_seq    = '0;
                n_next_seq    = '0;
                n_slots_free  = clamp_window(r_window_size);
                n_marks       = '0;
                n_marks_count = '0;
            end
            ACT_SEND: begin
                n_status                 = gbn_pkg::ST_FRAME_SENT;
                n_out_data.frame_valid   = 1'b1;
                n_out_data.frame_index   = r_next_index;
                n_out_data.frame_seq     = r_next_seq;
                n_next_index             = CW'(r_next_index + 1'b1);
                n_next_seq               = (next_seq_inc >= {1'b0, seq_mod}) ?
                                           '0 : next_seq_inc[SEQ_W-1:0];
                n_slots_free             = r_slots_free - 1'b1;
            end
            ACT_SLIDE: begin
                n_status = gbn_pkg::ST_ACK_ACCEPTED;
                n_marks[r_base_seq[MIX_W-1:0]] = 1'b1;
                if (r_marks_count >= r_act_window) begin
                    n_marks[old_seq[MIX_W-1:0]] = 1'b0;
                    n_marks_count = r_act_window;
                end else begin
                    n_marks_count = r_marks_count + 1'b1;
                end
                n_base_index = CW'(r_base_index + 1'b1);
                n_base_seq   = (base_seq_inc >= {1'b0, seq_mod}) ?
                               '0 : base_seq_inc[SEQ_W-1:0];
                if (r_slots_free < r_act_window) begin
                    n_slots_free = r_slots_free + 1'b1;
                end
            end
            ACT_IGNORE:  n_status = gbn_pkg::ST_IGNORED;
            ACT_BAD_SEQ: n_status = gbn_pkg::ST_BAD_SEQ;
            ACT_REWIND_NAK, ACT_REWIND_CORRUPT, ACT_REWIND_TIMEOUT: begin
                n_next_index = r_base_index;
                n_next_seq   = r_base_seq;
                n_slots_free = r_act_window;
                priority if (r_action == ACT_REWIND_NAK) begin
                    n_status = gbn_pkg::ST_NAK_REWIND;
                end else if (r_action == ACT_REWIND_CORRUPT) begin
                    n_status = gbn_pkg::ST_CORRUPT_REWIND;
                end else begin
                    n_status = gbn_pkg::ST_TIMEOUT_REWIND;
                end
            end
            default: n_status = gbn_pkg::ST_NONE;
        endcase
        n_out_data.status        = n_status;
        n_out_data.all_done      = n_started && (n_base_index == n_total) &&
                                   (n_next_index == n_total);
        n_out_data.next_send_seq = n_next_seq;
    end

    always_comb begin
        if (apply_en) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= gbn_pkg::BK_FETCH;
            r_window_size <= gbn_pkg::CFG_W'(gbn_pkg::WIN_RESET);
            r_act_window  <= clamp_window(gbn_pkg::CFG_W'(gbn_pkg::WIN_RESET));
            r_started     <= 1'b0;
            r_base_index  <= '0;
            r_next_index  <= '0;
            r_base_seq    <= '0;
            r_next_seq    <= '0;
            r_slots_free  <= '0;
            r_total       <= '0;
            r_marks       <= '0;
            r_marks_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_window_size <= i_cfg_wdata;
            end
            if (apply_en) begin
                r_act_window  <= n_act_window;
                r_started     <= n_started;
                r_base_index  <= n_base_index;
                r_next_index  <= n_next_index;
                r_base_seq    <= n_base_seq;
                r_next_seq    <= n_next_seq;
                r_slots_free  <= n_slots_free;
                r_total       <= n_total;
                r_marks       <= n_marks;
                r_marks_count <= n_marks_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fetch_en) begin
            r_action <= d_action;
            r_count  <= i_head.count;
        end
        if (apply_en) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
